@@ hdl/lsc_pkg.sv @@
// ----------------------------------------------------------------------------
// Line segment clipper package
// Shared constants, register indexes and the state encodings of the
// clipper and its multiply/divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lsc_pkg;

  // Default coordinate width
  localparam int CoordWidthDef = 16;

  // Window register width and reset values
  localparam int WinWidth = 15;
  localparam logic [WinWidth-1:0] WidthReset  = 15'd640;
  localparam logic [WinWidth-1:0] HeightReset = 15'd480;

  // Most border moves for one segment
  localparam logic [2:0] MaxMoves = 3'd4;

  // Configuration register indexes
  localparam int CfgIdxWidth = 1;
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_e;

  // Outcode bit positions
  localparam int OutLeft   = 0;
  localparam int OutRight  = 1;
  localparam int OutTop    = 2;
  localparam int OutBottom = 3;

  // Clipper sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_WAIT = 3'b100
  } clip_state_e;

  // Multiply/divide unit states
  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_state_e;

endpackage

`default_nettype wire

@@ hdl/lsc_muldiv.sv @@
// ----------------------------------------------------------------------------
// Iterative multiply-divide unit
// Computes floor(a * b / d) on magnitudes with one shared adder: a
// shift-add multiply of Width steps, then a restoring divide of Width steps.
// The quotient must fit in Width bits (b no larger than d).
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_muldiv #(
  parameter int Width = 18
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [Width-1:0] a_i,
  input  wire logic [Width-1:0] b_i,
  input  wire logic [Width-1:0] d_i,
  output logic                  done_o,
  output logic [Width-1:0]      q_o
);
  import lsc_pkg::*;

  localparam int CntWidth = $clog2(Width + 1);
  localparam logic [CntWidth-1:0] LastStep = CntWidth'(Width - 1);

  md_state_e state_q, state_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic [Width-1:0] hi_q, hi_d, lo_q, lo_d, ma_q, ma_d, md_q, md_d;
  logic done_q, done_d;

  logic [Width:0]   add_a, add_b;
  logic             add_cin;
  logic [Width+1:0] add_sum;
  logic             ge;

  // Shared adder: accumulate for multiply, trial subtract for divide
  always_comb begin
    if (state_q == MD_DIV) begin
      add_a   = {hi_q, lo_q[Width-1]};
      add_b   = ~{1'b0, md_q};
      add_cin = 1'b1;
    end else begin
      add_a   = {1'b0, hi_q};
      add_b   = {1'b0, (lo_q[0] ? ma_q : {Width{1'b0}})};
      add_cin = 1'b0;
    end
    add_sum = {1'b0, add_a} + {1'b0, add_b} + {{(Width+1){1'b0}}, add_cin};
    ge      = add_sum[Width+1];
  end

  // Advance the step sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    ma_d    = ma_q;
    md_d    = md_q;
    done_d  = 1'b0;
    case (state_q)
      MD_IDLE: begin
        if (start_i) begin
          hi_d    = '0;
          lo_d    = b_i;
          ma_d    = a_i;
          md_d    = d_i;
          cnt_d   = '0;
          state_d = MD_MUL;
        end
      end
      MD_MUL: begin
        hi_d  = add_sum[Width:1];
        lo_d  = {add_sum[0], lo_q[Width-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          cnt_d   = '0;
          state_d = MD_DIV;
        end
      end
      MD_DIV: begin
        hi_d  = ge ? add_sum[Width-1:0] : add_a[Width-1:0];
        lo_d  = {lo_q[Width-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          done_d  = 1'b1;
          state_d = MD_IDLE;
        end
      end
      default: state_d = MD_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Hold datapath
  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
    ma_q <= ma_d;
    md_q <= md_d;
  end

  assign done_o = done_q;
  assign q_o    = lo_q;

endmodule

`default_nettype wire

@@ hdl/line_segment_clipper.sv @@
// ----------------------------------------------------------------------------
// Line segment clipper
// Cohen-Sutherland clipping of one segment to a programmable window.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the four endpoint coordinates and raise start_i; the beat is taken
//   at a clock edge where start_i is high and busy_o is low. busy_o stays
//   high until the result is out. The result appears for exactly one cycle
//   with done_o high: visible_o and the clipped endpoints, all zero when
//   the segment is rejected. The receiver cannot stall the result.
//   Window size is written over the cfg channel (index 0 width, index 1
//   height); cfg_ready_o is always high, write only while busy_o is low.
// Sequence:
//   Each border move starts the shared multiply/divide unit, waits while it
//   runs a shift-add multiply and then a restoring divide on DW-bit operands,
//   and writes the moved endpoint back, where DW = max(COORD_WIDTH,16)+2.
//   done_o rises once both outcodes are clear, share a bit, or four moves
//   have been made; one segment at a time.
// Reset:
//   Clears the sequencer and loads the window registers with 640 x 480.
// ----------------------------------------------------------------------------
`default_nettype none

module line_segment_clipper #(
  parameter int COORD_WIDTH = lsc_pkg::CoordWidthDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [lsc_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  wire logic [lsc_pkg::WinWidth-1:0]      cfg_data_i,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic signed [COORD_WIDTH-1:0]     start_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]     start_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]     end_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]     end_y_i,
  output logic                                   done_o,
  output logic                                   visible_o,
  output logic signed [COORD_WIDTH-1:0]          clip_start_x_o,
  output logic signed [COORD_WIDTH-1:0]          clip_start_y_o,
  output logic signed [COORD_WIDTH-1:0]          clip_end_x_o,
  output logic signed [COORD_WIDTH-1:0]          clip_end_y_o
);
  import lsc_pkg::*;

  // Coordinate width holding the window borders; difference width
  localparam int EW = ((COORD_WIDTH > WinWidth + 1) ? COORD_WIDTH : WinWidth + 1) + 1;
  localparam int DW = EW + 1;

  clip_state_e state_q, state_d;
  logic [WinWidth-1:0] win_w_q, win_h_q;
  logic signed [EW-1:0] x1_q, y1_q, x2_q, y2_q, x1_d, y1_d, x2_d, y2_d;
  logic [2:0] moves_q, moves_d;
  logic neg_q, neg_d, dzero_q, dzero_d, axis_y_q, axis_y_d, sel1_q, sel1_d;
  logic signed [DW-1:0] base_q, base_d;
  logic signed [EW-1:0] border_q, border_d;
  logic done_q, done_d, vis_q, vis_d;
  logic signed [COORD_WIDTH-1:0] ox1_q, oy1_q, ox2_q, oy2_q;
  logic signed [COORD_WIDTH-1:0] ox1_d, oy1_d, ox2_d, oy2_d;

  logic signed [EW-1:0] w_ext, h_ext;
  logic [3:0] c1, c2, oc;
  logic signed [DW-1:0] dx, dy, wm1, hm1, op_a, op_b, op_d;
  logic [DW-1:0] mag_a, mag_b, mag_d;
  logic md_start, md_done;
  logic [DW-1:0] md_q;
  logic signed [DW-1:0] q_signed, new_c;

  // Window borders as signed coordinates
  assign w_ext = EW'({1'b0, win_w_q});
  assign h_ext = EW'({1'b0, win_h_q});
  assign wm1   = DW'(w_ext) - DW'(1);
  assign hm1   = DW'(h_ext) - DW'(1);

  // Outcodes of both endpoints
  always_comb begin
    c1 = '0;
    c2 = '0;
    c1[OutLeft]   = x1_q < 0;
    c1[OutRight]  = !(x1_q < 0) && (x1_q >= w_ext);
    c1[OutTop]    = y1_q < 0;
    c1[OutBottom] = !(y1_q < 0) && (y1_q >= h_ext);
    c2[OutLeft]   = x2_q < 0;
    c2[OutRight]  = !(x2_q < 0) && (x2_q >= w_ext);
    c2[OutTop]    = y2_q < 0;
    c2[OutBottom] = !(y2_q < 0) && (y2_q >= h_ext);
  end

  // Pick the border and the operands of the crossing
  always_comb begin
    dx = DW'(x2_q) - DW'(x1_q);
    dy = DW'(y2_q) - DW'(y1_q);
    oc = (c1 != 4'd0) ? c1 : c2;
    if (oc[OutBottom]) begin
      op_a = dx; op_b = hm1 - DW'(y1_q); op_d = dy;
      axis_y_d = 1'b1; border_d = EW'(hm1); base_d = DW'(x1_q);
    end else if (oc[OutTop]) begin
      op_a = dx; op_b = -DW'(y1_q); op_d = dy;
      axis_y_d = 1'b1; border_d = '0; base_d = DW'(x1_q);
    end else if (oc[OutRight]) begin
      op_a = dy; op_b = wm1 - DW'(x1_q); op_d = dx;
      axis_y_d = 1'b0; border_d = EW'(wm1); base_d = DW'(y1_q);
    end else begin
      op_a = dy; op_b = -DW'(x1_q); op_d = dx;
      axis_y_d = 1'b0; border_d = '0; base_d = DW'(y1_q);
    end
    mag_a   = op_a[DW-1] ? DW'(-op_a) : DW'(op_a);
    mag_b   = op_b[DW-1] ? DW'(-op_b) : DW'(op_b);
    mag_d   = op_d[DW-1] ? DW'(-op_d) : DW'(op_d);
    neg_d   = op_a[DW-1] ^ op_b[DW-1] ^ op_d[DW-1];
    dzero_d = (op_d == '0);
    sel1_d  = (c1 != 4'd0);
  end

  // Apply the quotient to the moved endpoint
  assign q_signed = dzero_q ? '0 : (neg_q ? -$signed(md_q) : $signed(md_q));
  assign new_c    = base_q + q_signed;

  // Sequence the clip passes
  always_comb begin
    state_d  = state_q;
    x1_d = x1_q; y1_d = y1_q; x2_d = x2_q; y2_d = y2_q;
    moves_d  = moves_q;
    done_d   = 1'b0;
    vis_d    = vis_q;
    ox1_d = ox1_q; oy1_d = oy1_q; ox2_d = ox2_q; oy2_d = oy2_q;
    md_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          x1_d    = EW'(start_x_i);
          y1_d    = EW'(start_y_i);
          x2_d    = EW'(end_x_i);
          y2_d    = EW'(end_y_i);
          moves_d = '0;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if ((c1 | c2) == 4'd0) begin
          done_d  = 1'b1;
          vis_d   = 1'b1;
          ox1_d   = x1_q[COORD_WIDTH-1:0];
          oy1_d   = y1_q[COORD_WIDTH-1:0];
          ox2_d   = x2_q[COORD_WIDTH-1:0];
          oy2_d   = y2_q[COORD_WIDTH-1:0];
          state_d = ST_IDLE;
        end else if (((c1 & c2) != 4'd0) || (moves_q == MaxMoves)) begin
          done_d  = 1'b1;
          vis_d   = 1'b0;
          ox1_d   = '0;
          oy1_d   = '0;
          ox2_d   = '0;
          oy2_d   = '0;
          state_d = ST_IDLE;
        end else begin
          md_start = 1'b1;
          state_d  = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (md_done) begin
          moves_d = moves_q + 3'd1;
          state_d = ST_EVAL;
          if (sel1_q) begin
            x1_d = axis_y_q ? EW'(new_c) : border_q;
            y1_d = axis_y_q ? border_q : EW'(new_c);
          end else begin
            x2_d = axis_y_q ? EW'(new_c) : border_q;
            y2_d = axis_y_q ? border_q : EW'(new_c);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold control state and window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      moves_q <= '0;
      done_q  <= 1'b0;
      win_w_q <= WidthReset;
      win_h_q <= HeightReset;
    end else begin
      state_q <= state_d;
      moves_q <= moves_d;
      done_q  <= done_d;
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_WIDTH:  win_w_q <= cfg_data_i;
          REG_HEIGHT: win_h_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Hold coordinates, pass operands and results
  always_ff @(posedge clk_i) begin
    x1_q  <= x1_d;
    y1_q  <= y1_d;
    x2_q  <= x2_d;
    y2_q  <= y2_d;
    vis_q <= vis_d;
    ox1_q <= ox1_d;
    oy1_q <= oy1_d;
    ox2_q <= ox2_d;
    oy2_q <= oy2_d;
    if (md_start) begin
      neg_q    <= neg_d;
      dzero_q  <= dzero_d;
      axis_y_q <= axis_y_d;
      sel1_q   <= sel1_d;
      base_q   <= base_d;
      border_q <= border_d;
    end
  end

  lsc_muldiv #(
    .Width(DW)
  ) u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(md_start),
    .a_i    (mag_a),
    .b_i    (mag_b),
    .d_i    (mag_d),
    .done_o (md_done),
    .q_o    (md_q)
  );

  assign cfg_ready_o    = 1'b1;
  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign visible_o      = vis_q;
  assign clip_start_x_o = ox1_q;
  assign clip_start_y_o = oy1_q;
  assign clip_end_x_o   = ox2_q;
  assign clip_end_y_o   = oy2_q;

endmodule

`default_nettype wire
